### rtl/ssn_pkg.sv
// shared types and constants of the shelf sheet nesting block
// no dependencies; imported by ssn_alu, ssn_ctrl and the top level of the block
package ssn_pkg;

  localparam int DEF_MAX_PIECES = 32;

  localparam int DIM_W    = 16;
  localparam int ALU_W    = 20;
  localparam int CURSOR_W = 18;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;

  localparam logic [CURSOR_W-1:0] CURSOR_MAX = 18'h3FFFF;
  localparam logic [4:0]          SHEET_MAX  = 5'd31;

  localparam logic [CFG_IDX_W-1:0] REG_SHEET_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHEET_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_SPACING = 2'd3;

  localparam logic [DIM_W-1:0] RST_SHEET_WIDTH   = 16'd6000;
  localparam logic [DIM_W-1:0] RST_SHEET_HEIGHT  = 16'd4000;
  localparam logic [DIM_W-1:0] RST_EDGE_MARGIN   = 16'd50;
  localparam logic [DIM_W-1:0] RST_PIECE_SPACING = 16'd30;

  typedef struct packed {
    logic [DIM_W-1:0] sheet_width;
    logic [DIM_W-1:0] sheet_height;
    logic [DIM_W-1:0] edge_margin;
    logic [DIM_W-1:0] piece_spacing;
  } ssn_cfg_t;

  // operands are two's complement, compare is signed
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [ALU_W-1:0] c;
    logic             sub;
  } ssn_alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             gt;
  } ssn_alu_rsp_t;

endpackage

### rtl/ssn_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module ssn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/ssn_alu.sv
// shared add/subtract and signed compare unit of the placement sequencer
// depends on ssn_pkg
module ssn_alu import ssn_pkg::*; (
  input  ssn_alu_req_t req,
  output ssn_alu_rsp_t rsp
);

  logic [ALU_W-1:0] sum;

  assign sum     = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign rsp.sum = sum;
  assign rsp.gt  = $signed(sum) > $signed(req.c);

endmodule

### rtl/ssn_ctrl.sv
// load, height scan and shelf placement sequencer with result register
// depends on ssn_pkg; drives the piece stores and the shared alu
module ssn_ctrl import ssn_pkg::*; #(
  parameter int MAX_PIECES = DEF_MAX_PIECES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ssn_cfg_t                      cfg,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [IN_DATA_W-1:0]          s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OUT_DATA_W-1:0]         m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic                          ram_we,
  output logic [$clog2(MAX_PIECES)-1:0] ram_waddr,
  output logic [DIM_W-1:0]              ram_wdata_w,
  output logic [DIM_W-1:0]              ram_wdata_h,
  output logic [$clog2(MAX_PIECES)-1:0] ram_raddr,
  input  logic [DIM_W-1:0]              ram_rdata_w,
  input  logic [DIM_W-1:0]              ram_rdata_h,
  output ssn_alu_req_t                  alu_req,
  input  ssn_alu_rsp_t                  alu_rsp
);

  localparam int IW = $clog2(MAX_PIECES);
  localparam int CW = $clog2(MAX_PIECES + 1);

  localparam logic [4:0] ST_LOAD = 5'd0;
  localparam logic [4:0] ST_LIM0 = 5'd1;
  localparam logic [4:0] ST_LIM1 = 5'd2;
  localparam logic [4:0] ST_LIM2 = 5'd3;
  localparam logic [4:0] ST_LIM3 = 5'd4;
  localparam logic [4:0] ST_SCAN = 5'd5;
  localparam logic [4:0] ST_OVW  = 5'd6;
  localparam logic [4:0] ST_OVH  = 5'd7;
  localparam logic [4:0] ST_BRK0 = 5'd8;
  localparam logic [4:0] ST_BRK1 = 5'd9;
  localparam logic [4:0] ST_BRK2 = 5'd10;
  localparam logic [4:0] ST_BRK3 = 5'd11;
  localparam logic [4:0] ST_SHT  = 5'd12;
  localparam logic [4:0] ST_EMIT = 5'd13;
  localparam logic [4:0] ST_ADV0 = 5'd14;
  localparam logic [4:0] ST_ADV1 = 5'd15;
  localparam logic [4:0] ST_SHF  = 5'd16;

  logic [4:0]            state;
  logic [CW-1:0]         piece_count;
  logic [CW-1:0]         n_pieces;
  logic [MAX_PIECES-1:0] placed;
  logic [CW-1:0]         scan_cnt;
  logic                  rd_pend;
  logic [IW-1:0]         rd_idx;
  logic                  found;
  logic [IW-1:0]         best_idx;
  logic [DIM_W-1:0]      best_w;
  logic [DIM_W-1:0]      best_h;
  logic [CW-1:0]         placed_cnt;
  logic [ALU_W-1:0]      wlim;
  logic [ALU_W-1:0]      wlim2;
  logic [ALU_W-1:0]      hlim;
  logic [ALU_W-1:0]      hlim2;
  logic                  over;
  logic                  brk_a;
  logic [DIM_W:0]        tmp;
  logic [CURSOR_W-1:0]   cursor_x;
  logic [CURSOR_W-1:0]   cursor_y;
  logic [DIM_W-1:0]      shelf_height;
  logic [4:0]            sheet_index;

  logic                  out_valid;
  logic [4:0]            out_index;
  logic [4:0]            out_sheet;
  logic [DIM_W-1:0]      out_x;
  logic [DIM_W-1:0]      out_y;
  logic                  out_over;
  logic [5:0]            out_sheets;
  logic                  out_last;

  logic                  in_accept;
  logic                  store_en;
  logic [CW-1:0]         count_next;
  logic                  emit_ok;
  logic                  is_final;
  logic [IW+4:0]         idx_ext;
  logic [CURSOR_W-1:0]   margin18;
  logic [CURSOR_W-1:0]   cursor_sum;

  assign s_axis_tready = (state == ST_LOAD);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign store_en      = in_accept && (piece_count < CW'(MAX_PIECES));
  assign count_next    = piece_count + CW'(store_en);

  assign ram_we      = store_en;
  assign ram_waddr   = piece_count[IW-1:0];
  assign ram_wdata_w = s_axis_tdata[DIM_W-1:0];
  assign ram_wdata_h = s_axis_tdata[2*DIM_W-1:DIM_W];
  assign ram_raddr   = scan_cnt[IW-1:0];

  assign emit_ok    = !out_valid || m_axis_tready;
  assign is_final   = (placed_cnt + CW'(1)) == n_pieces;
  assign idx_ext    = {5'b0, best_idx};
  assign margin18   = {2'b0, cfg.edge_margin};
  assign cursor_sum = alu_rsp.gt ? CURSOR_MAX : alu_rsp.sum[CURSOR_W-1:0];

  // operand selection for the shared unit
  always_comb begin
    alu_req = '0;
    case (state)
      ST_LIM0: begin
        alu_req.a   = {4'b0, cfg.sheet_width};
        alu_req.b   = {4'b0, cfg.edge_margin};
        alu_req.sub = 1'b1;
      end
      ST_LIM1: begin
        alu_req.a   = wlim;
        alu_req.b   = {4'b0, cfg.edge_margin};
        alu_req.sub = 1'b1;
      end
      ST_LIM2: begin
        alu_req.a   = {4'b0, cfg.sheet_height};
        alu_req.b   = {4'b0, cfg.edge_margin};
        alu_req.sub = 1'b1;
      end
      ST_LIM3: begin
        alu_req.a   = hlim;
        alu_req.b   = {4'b0, cfg.edge_margin};
        alu_req.sub = 1'b1;
      end
      ST_SCAN: begin
        alu_req.a = {4'b0, ram_rdata_h};
        alu_req.c = {4'b0, best_h};
      end
      ST_OVW: begin
        alu_req.a = {4'b0, best_w};
        alu_req.c = wlim2;
      end
      ST_OVH: begin
        alu_req.a = {4'b0, best_h};
        alu_req.c = hlim2;
      end
      ST_BRK0: begin
        alu_req.a = {2'b0, cursor_x};
        alu_req.c = {4'b0, cfg.edge_margin};
      end
      ST_BRK1: begin
        alu_req.a = {2'b0, cursor_x};
        alu_req.b = {4'b0, best_w};
        alu_req.c = wlim;
      end
      ST_BRK2: begin
        alu_req.a = {4'b0, shelf_height};
        alu_req.b = {4'b0, cfg.piece_spacing};
      end
      ST_BRK3: begin
        alu_req.a = {2'b0, cursor_y};
        alu_req.b = {3'b0, tmp};
        alu_req.c = {2'b0, CURSOR_MAX};
      end
      ST_SHT: begin
        alu_req.a = {2'b0, cursor_y};
        alu_req.b = {4'b0, best_h};
        alu_req.c = hlim;
      end
      ST_ADV0: begin
        alu_req.a = {4'b0, best_w};
        alu_req.b = {4'b0, cfg.piece_spacing};
      end
      ST_ADV1: begin
        alu_req.a = {2'b0, cursor_x};
        alu_req.b = {3'b0, tmp};
        alu_req.c = {2'b0, CURSOR_MAX};
      end
      ST_SHF: begin
        alu_req.a = {4'b0, best_h};
        alu_req.c = {4'b0, shelf_height};
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      piece_count <= '0;
      placed      <= '0;
      out_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      found       <= 1'b0;
    end else begin
      // in the emit step a new result replaces the one leaving
      if (m_axis_tvalid && m_axis_tready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (in_accept) begin
            if (s_axis_tlast) begin
              n_pieces     <= count_next;
              piece_count  <= '0;
              placed       <= '0;
              placed_cnt   <= '0;
              cursor_x     <= margin18;
              cursor_y     <= margin18;
              shelf_height <= '0;
              sheet_index  <= '0;
              state        <= ST_LIM0;
            end else begin
              piece_count <= count_next;
            end
          end
        end
        ST_LIM0: begin
          wlim  <= alu_rsp.sum;
          state <= ST_LIM1;
        end
        ST_LIM1: begin
          wlim2 <= alu_rsp.sum;
          state <= ST_LIM2;
        end
        ST_LIM2: begin
          hlim  <= alu_rsp.sum;
          state <= ST_LIM3;
        end
        ST_LIM3: begin
          hlim2    <= alu_rsp.sum;
          scan_cnt <= '0;
          rd_pend  <= 1'b0;
          found    <= 1'b0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          // one store read issued per cycle, compared in the cycle after
          if (scan_cnt < n_pieces) begin
            scan_cnt <= scan_cnt + CW'(1);
            rd_pend  <= 1'b1;
            rd_idx   <= scan_cnt[IW-1:0];
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend && !placed[rd_idx] && (!found || alu_rsp.gt)) begin
            found    <= 1'b1;
            best_idx <= rd_idx;
            best_w   <= ram_rdata_w;
            best_h   <= ram_rdata_h;
          end
          if ((scan_cnt == n_pieces) && !rd_pend) begin
            placed[best_idx] <= 1'b1;
            state            <= ST_OVW;
          end
        end
        ST_OVW: begin
          over  <= alu_rsp.gt;
          state <= ST_OVH;
        end
        ST_OVH: begin
          over  <= over || alu_rsp.gt;
          state <= ST_BRK0;
        end
        ST_BRK0: begin
          brk_a <= alu_rsp.gt;
          state <= ST_BRK1;
        end
        ST_BRK1: begin
          state <= (brk_a && alu_rsp.gt) ? ST_BRK2 : ST_SHT;
        end
        ST_BRK2: begin
          tmp   <= alu_rsp.sum[DIM_W:0];
          state <= ST_BRK3;
        end
        ST_BRK3: begin
          cursor_x     <= margin18;
          cursor_y     <= cursor_sum;
          shelf_height <= '0;
          state        <= ST_SHT;
        end
        ST_SHT: begin
          if (alu_rsp.gt) begin
            if (sheet_index != SHEET_MAX) begin
              sheet_index <= sheet_index + 5'd1;
            end
            cursor_x     <= margin18;
            cursor_y     <= margin18;
            shelf_height <= '0;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid  <= 1'b1;
            out_index  <= idx_ext[4:0];
            out_sheet  <= sheet_index;
            out_x      <= (cursor_x[CURSOR_W-1:DIM_W] != '0) ? '1 : cursor_x[DIM_W-1:0];
            out_y      <= (cursor_y[CURSOR_W-1:DIM_W] != '0) ? '1 : cursor_y[DIM_W-1:0];
            out_over   <= over;
            out_sheets <= is_final ? ({1'b0, sheet_index} + 6'd1) : 6'd0;
            out_last   <= is_final;
            state      <= ST_ADV0;
          end
        end
        ST_ADV0: begin
          tmp   <= alu_rsp.sum[DIM_W:0];
          state <= ST_ADV1;
        end
        ST_ADV1: begin
          cursor_x <= cursor_sum;
          state    <= ST_SHF;
        end
        ST_SHF: begin
          if (alu_rsp.gt) begin
            shelf_height <= best_h;
          end
          placed_cnt <= placed_cnt + CW'(1);
          scan_cnt   <= '0;
          rd_pend    <= 1'b0;
          found      <= 1'b0;
          state      <= is_final ? ST_LOAD : ST_SCAN;
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {7'b0, out_sheets, out_over, out_y, out_x, out_sheet, out_index};

  // every scan starts with exactly the pieces already placed marked
  a_scan_mask: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ($countones(placed) == int'(placed_cnt)))
    else $error("placed mask out of step with placement count");

  // the chosen piece is marked as soon as the scan ends
  a_best_marked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OVW) |-> (found && placed[best_idx]))
    else $error("scan ended without a marked best piece");

  // sheet count rides only on the closing result
  a_count_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_sheets != 6'd0)))
    else $error("sheet count and last flag disagree");

  // a stalled result register holds placement back
  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_valid && !m_axis_tready) |=> (state == ST_EMIT))
    else $error("result overwritten while stalled");

endmodule

### rtl/shelf_sheet_nesting_top.sv
// top level of the shelf sheet nesting block: config registers, piece stores,
// shared alu and sequencer; depends on ssn_pkg, ssn_ram, ssn_alu, ssn_ctrl
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata = piece_width, piece_height; tlast = last_piece
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata = index, sheet, x, y, oversize, sheets_used;
//                                             tlast = final_result
// cfg       in   cfg_we (no wait)             cfg_index selects register, cfg_data value
//
// pieces load at one transfer per cycle; the transfer marked last starts packing
// packing first works out the sheet limits, then per piece scans the height store
// (one read port) and takes 8 to 10 steps of the shared alu and one emit step;
// s_axis_tready stays low for the whole run
// a stalled result holds the sequencer in its emit step; the final result may
// still wait while the next set loads
// reset is synchronous; the stores are not cleared, a run reads only what it loaded
module shelf_sheet_nesting_top import ssn_pkg::*; #(
  parameter int MAX_PIECES = DEF_MAX_PIECES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] piece_width, [31:16] piece_height
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [4:0] piece_index, [9:5] sheet_number, [25:10] place_x, [41:26] place_y,
  // [42] oversize, [48:43] sheets_used, [55:49] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data
);

  localparam int IW = $clog2(MAX_PIECES);

  ssn_cfg_t         cfg;
  ssn_alu_req_t     alu_req;
  ssn_alu_rsp_t     alu_rsp;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [IW-1:0]    ram_raddr;
  logic [DIM_W-1:0] ram_wdata_w;
  logic [DIM_W-1:0] ram_wdata_h;
  logic [DIM_W-1:0] ram_rdata_w;
  logic [DIM_W-1:0] ram_rdata_h;

  // configuration registers; the user must write them only between runs, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sheet_width   <= RST_SHEET_WIDTH;
      cfg.sheet_height  <= RST_SHEET_HEIGHT;
      cfg.edge_margin   <= RST_EDGE_MARGIN;
      cfg.piece_spacing <= RST_PIECE_SPACING;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHEET_WIDTH:   cfg.sheet_width   <= cfg_data;
        REG_SHEET_HEIGHT:  cfg.sheet_height  <= cfg_data;
        REG_EDGE_MARGIN:   cfg.edge_margin   <= cfg_data;
        REG_PIECE_SPACING: cfg.piece_spacing <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // piece width store
  ssn_ram #(
    .WIDTH (DIM_W),
    .DEPTH (MAX_PIECES)
  ) u_width_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata_w),
    .raddr (ram_raddr),
    .rdata (ram_rdata_w)
  );

  // piece height store
  ssn_ram #(
    .WIDTH (DIM_W),
    .DEPTH (MAX_PIECES)
  ) u_height_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata_h),
    .raddr (ram_raddr),
    .rdata (ram_rdata_h)
  );

  // one adder/comparator serves limits, scan compares and cursor updates
  ssn_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ssn_ctrl #(
    .MAX_PIECES (MAX_PIECES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata_w   (ram_wdata_w),
    .ram_wdata_h   (ram_wdata_h),
    .ram_raddr     (ram_raddr),
    .ram_rdata_w   (ram_rdata_w),
    .ram_rdata_h   (ram_rdata_h),
    .alu_req       (alu_req),
    .alu_rsp       (alu_rsp)
  );

endmodule

### test/ssn_placement_checker.sv
// scoreboard for the shelf sheet nesting block: watches the piece, result and
// register-write channels and predicts every placement; depends on ssn_pkg
`timescale 1ns / 1ps
module ssn_placement_checker import ssn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]      cfg_data,
  output int                    mismatch_count,
  output int                    placements_due
);

  localparam int     SET_MAX    = DEF_MAX_PIECES;
  localparam longint CURSOR_TOP = longint'(CURSOR_MAX);

  typedef struct packed {
    logic [4:0]  index;
    logic [4:0]  sheet;
    logic [15:0] x;
    logic [15:0] y;
    logic        oversize;
    logic [5:0]  sheets_used;
    logic        closing;
  } placement_t;

  ssn_cfg_t         sheet_cfg;
  logic [DIM_W-1:0] width_mem  [SET_MAX];
  logic [DIM_W-1:0] height_mem [SET_MAX];
  int               loaded;
  placement_t       placements_q [$];

  function automatic longint grow_cursor(longint base, longint step);
    return (base + step > CURSOR_TOP) ? CURSOR_TOP : base + step;
  endfunction

  function automatic logic [15:0] clip_dim(longint v);
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // tallest first, ties to the lower load index, laid out in shelves
  function automatic void pack_set();
    longint margin, gap, right_edge, top_edge, cx, cy, pw, ph, shelf;
    int sheet, best;
    bit found;
    logic [SET_MAX-1:0] taken;
    placement_t p;
    margin     = sheet_cfg.edge_margin;
    gap        = sheet_cfg.piece_spacing;
    right_edge = longint'(sheet_cfg.sheet_width) - margin;
    top_edge   = longint'(sheet_cfg.sheet_height) - margin;
    cx = margin;
    cy = margin;
    shelf = 0;
    sheet = 0;
    taken = '0;
    for (int k = 0; k < loaded; k++) begin
      found = 1'b0;
      best = 0;
      for (int i = 0; i < loaded; i++)
        if (!taken[i] && (!found || height_mem[i] > height_mem[best])) begin
          best = i;
          found = 1'b1;
        end
      taken[best] = 1'b1;
      pw = width_mem[best];
      ph = height_mem[best];
      p = '0;
      p.oversize = (pw > right_edge - margin) || (ph > top_edge - margin);
      if (cx > margin && cx + pw > right_edge) begin
        cx = margin;
        cy = grow_cursor(cy, shelf + gap);
        shelf = 0;
      end
      if (cy + ph > top_edge) begin
        if (sheet < SHEET_MAX) sheet++;
        cx = margin;
        cy = margin;
        shelf = 0;
      end
      p.index = 5'(best);
      p.sheet = 5'(sheet);
      p.x = clip_dim(cx);
      p.y = clip_dim(cy);
      if (k == loaded - 1) begin
        p.sheets_used = 6'(sheet + 1);
        p.closing = 1'b1;
      end
      placements_q = {placements_q, p};
      cx = grow_cursor(cx, pw + gap);
      if (ph > shelf) shelf = ph;
    end
    loaded = 0;
  endfunction

  function automatic void take_piece(logic [IN_DATA_W-1:0] data, logic last);
    if (loaded < SET_MAX) begin
      width_mem[loaded]  = data[15:0];
      height_mem[loaded] = data[31:16];
      loaded++;
    end
    if (last) pack_set();
  endfunction

  function automatic void check_placement(logic [OUT_DATA_W-1:0] data, logic last);
    placement_t want, got;
    got.index       = data[4:0];
    got.sheet       = data[9:5];
    got.x           = data[25:10];
    got.y           = data[41:26];
    got.oversize    = data[42];
    got.sheets_used = data[48:43];
    got.closing     = last;
    if (placements_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: placement with none pending: idx %0d sheet %0d x %0d y %0d",
                 $realtime, got.index, got.sheet, got.x, got.y);
      return;
    end
    want = placements_q.pop_front();
    if (got != want || data[OUT_DATA_W-1:49] != '0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $write("%0t: placement mismatch exp idx %0d sheet %0d x %0d y %0d ovr %0b",
               $realtime, want.index, want.sheet, want.x, want.y, want.oversize);
        $write(" used %0d last %0b | got idx %0d sheet %0d x %0d y %0d ovr %0b",
               want.sheets_used, want.closing, got.index, got.sheet, got.x, got.y,
               got.oversize);
        $display(" used %0d last %0b pad %0h",
                 got.sheets_used, got.closing, data[OUT_DATA_W-1:49]);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sheet_cfg.sheet_width   = RST_SHEET_WIDTH;
      sheet_cfg.sheet_height  = RST_SHEET_HEIGHT;
      sheet_cfg.edge_margin   = RST_EDGE_MARGIN;
      sheet_cfg.piece_spacing = RST_PIECE_SPACING;
      loaded = 0;
      placements_q.delete();
    end else begin
      if (cfg_we)
        case (cfg_index)
          REG_SHEET_WIDTH:   sheet_cfg.sheet_width   = cfg_data;
          REG_SHEET_HEIGHT:  sheet_cfg.sheet_height  = cfg_data;
          REG_EDGE_MARGIN:   sheet_cfg.edge_margin   = cfg_data;
          REG_PIECE_SPACING: sheet_cfg.piece_spacing = cfg_data;
          default: ;
        endcase
      if (s_axis_tvalid && s_axis_tready) take_piece(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_placement(m_axis_tdata, m_axis_tlast);
    end
    placements_due = placements_q.size();
  end

endmodule

### test/shelf_sheet_nesting_top_test.sv
// stimulus and verdict for the shelf sheet nesting block: piece sets under many
// sheet settings with bursty input and a stalling result side; depends on
// ssn_pkg, shelf_sheet_nesting_top and ssn_placement_checker
`timescale 1ns / 1ps
module shelf_sheet_nesting_top_test;
  import ssn_pkg::*;

  localparam int ITEM_TARGET   = 260;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 20;

  // how the result side decides to take a transfer
  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} ready_mode_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [15:0] piece_width, [31:16] piece_height
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [4:0] piece_index, [9:5] sheet_number, [25:10] place_x, [41:26] place_y,
  // [42] oversize, [48:43] sheets_used, [55:49] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SHEET_WIDTH;
  logic [DIM_W-1:0]      cfg_data = '0;

  int mismatches;
  int placements_due;
  int items_sent = 0;
  int burst_left = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int cycle_count = 0;

  // copy of the sheet settings, only used to scale random piece sizes
  logic [DIM_W-1:0] cur_width  = RST_SHEET_WIDTH;
  logic [DIM_W-1:0] cur_height = RST_SHEET_HEIGHT;

  always #5 clk = ~clk;

  shelf_sheet_nesting_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  ssn_placement_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .placements_due (placements_due)
  );

  // result side: a stall mode picked at random for a random stretch, plus a long
  // hold-off whenever the stimulus asks for one
  initial begin : rx_side
    int mode_left;
    ready_mode_e mode;
    mode_left = 0;
    mode = READY_ALWAYS;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode = ready_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          READY_ALWAYS: m_axis_tready <= 1'b1;
          READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          READY_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
          default:      m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // run-away guard
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // one piece transfer; the sender works in bursts with random gaps between them
  task automatic push_piece(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {h, w};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // stop offering pieces until every placement of the set has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (placements_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // all four registers on consecutive cycles, block idle
  task automatic configure(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [DIM_W-1:0] margin, input logic [DIM_W-1:0] gap);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SHEET_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_SHEET_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= REG_EDGE_MARGIN;
    cfg_data  <= margin;
    @(posedge clk);
    cfg_index <= REG_PIECE_SPACING;
    cfg_data  <= gap;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_width  = w;
    cur_height = h;
  endtask

  // mostly sized to the sheet, sometimes a full-range value or an extreme
  function automatic logic [DIM_W-1:0] random_dim(int span);
    case ($urandom_range(0, 11))
      0:       return 16'($urandom_range(0, 65535));
      1:       return '0;
      2:       return '1;
      default: return 16'($urandom_range(0, span));
    endcase
  endfunction

  task automatic send_random_set(input int count);
    for (int i = 0; i < count; i++)
      push_piece(random_dim(cur_width / 3 + 1), random_dim(cur_height / 3 + 1),
                 i == count - 1);
  endtask

  task automatic pick_config();
    logic [DIM_W-1:0] w, h;
    case ($urandom_range(0, 7))
      // anything the registers hold
      0: configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      // biggest sheet, no margin and no spacing
      1: configure('1, '1, '0, '0);
      // margin over half the sheet width: usable width below zero
      2: begin
        w = 16'($urandom_range(200, 2000));
        h = 16'($urandom_range(200, 2000));
        configure(w, h, 16'(w / 2 + $urandom_range(1, 300)), 16'($urandom_range(0, 50)));
      end
      default: configure(16'($urandom_range(1000, 8000)), 16'($urandom_range(1000, 6000)),
                         16'($urandom_range(0, 100)), 16'($urandom_range(0, 60)));
    endcase
  endtask

  initial begin : stimulus
    int set_len;
    bit held;
    held = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: a lone empty piece, then a mix with an oversize piece,
    // an equal-height tie and a row overflow
    push_piece('0, '0, 1'b1);
    drain();
    push_piece('1, '1, 1'b0);
    push_piece(16'd1000, 16'd500, 1'b0);
    push_piece(16'd1000, 16'd500, 1'b0);
    push_piece(16'd3000, 16'd800, 1'b0);
    push_piece(16'd2500, 16'd800, 1'b0);
    push_piece(16'd5000, 16'd1200, 1'b1);
    drain();

    // zero-size sheet
    configure('0, '0, '0, '0);
    push_piece('0, '0, 1'b0);
    push_piece(16'd1, 16'd1, 1'b0);
    push_piece('0, 16'd5, 1'b1);
    drain();

    // largest sheet with the largest spacing
    configure('1, '1, '0, '1);
    push_piece('1, 16'd1, 1'b0);
    push_piece(16'd1, '1, 1'b0);
    push_piece(16'd32768, 16'd100, 1'b1);
    drain();

    // margin wider than half the sheet
    configure(16'd100, 16'd100, 16'd60, '0);
    push_piece('0, '0, 1'b0);
    push_piece(16'd10, 16'd10, 1'b1);
    drain();

    // every piece spills to a fresh sheet so the sheet count saturates, and the
    // set runs past the store so the marked piece itself is dropped
    configure(16'd1000, 16'd1000, 16'd600, 16'd10);
    send_random_set(34);
    drain();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 1) == 0) pick_config();
      case ($urandom_range(0, 9))
        0, 1:    set_len = $urandom_range(13, 32);
        2:       set_len = $urandom_range(33, 36);
        default: set_len = $urandom_range(1, 12);
      endcase
      if (!held && items_sent > 120) begin
        // results held back for a long stretch while the next set is offered
        held = 1'b1;
        holds_asked++;
        send_random_set($urandom_range(6, 10));
        send_random_set($urandom_range(2, 10));
      end else
        send_random_set(set_len);
      drain();
    end

    if (mismatches == 0 && placements_due == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
